// ===== rtl/krt_pkg.sv =====
// Shared widths, codes and types for the key repeat timer.
package krt_pkg;

   localparam int REQ_TYPE_BITS  = 2;
   localparam int TICK_PORT_BITS = 32;
   localparam int HOLD_BITS      = 17;
   localparam int INTERVAL_BITS  = 16;
   localparam int COUNT_BITS     = 4;
   localparam int RSP_DATA_BITS  = 8;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [REQ_TYPE_BITS-1:0] REQ_PRESS   = 2'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_RELEASE = 2'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_POLL    = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TIME     = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTERVAL_TIME = 1'b1;

   localparam logic [HOLD_BITS-1:0]     HOLD_RESET     = 17'd500;
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 16'd30;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/krt_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module krt_div #(
   parameter int DW = 31
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [DW-1:0]                     dividend,
   input  logic [krt_pkg::INTERVAL_BITS-1:0] divisor,
   output logic [DW-1:0]                     quotient,
   output krt_pkg::div_stat_type             stat
);
   import krt_pkg::*;

   localparam int CW = $clog2(DW + 1);

   logic [INTERVAL_BITS-1:0] rem_ff, rem_in;
   logic [INTERVAL_BITS-1:0] dsr_ff, dsr_in;
   logic [DW-1:0]            quo_ff, quo_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [INTERVAL_BITS:0]   trial;
   logic [INTERVAL_BITS+1:0] sub;
   logic                     ge;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign sub   = {1'b0, trial} - {2'b00, dsr_ff};
   assign ge    = ~sub[INTERVAL_BITS+1];

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? sub[INTERVAL_BITS-1:0] : trial[INTERVAL_BITS-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/krt_out.sv =====
// Output register that holds a repeat count until the response transfer.
module krt_out (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [krt_pkg::COUNT_BITS-1:0]     count,
   output logic                               free,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [krt_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import krt_pkg::*;

   logic                  valid_ff, valid_in;
   logic [COUNT_BITS-1:0] data_ff, data_in;

   assign free = ~valid_ff | rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(data_ff);

endmodule

// ===== rtl/key_repeat_timer_top.sv =====
// Top level of the key repeat timer: request sequencer, state and configuration.
//
//   Channel  Direction  Payload
//   req      in         tdata: now_tick[31:0]; tuser: req_type[1:0]
//   rsp      out        tdata: repeat_count[3:0], zero filled to 8 bits
//   csr      in         csr_index selects hold_time (0) or interval_time (1)
//
// A press or release is done with its transfer. A poll with repeats active passes
// through ST_DIFF and ST_ELAP, which form the elapsed time, then the bit-serial
// divider runs; ST_DONE waits for it to finish and loads the count into the output register.
// A poll with repeats off goes from the transfer straight to ST_DONE, and one still
// inside the hold time skips the divider. Reset is synchronous and clears the held
// flag and the counters.
// A waiting response does not block requests; a poll only stalls at its end
// while the output register is still full.
module key_repeat_timer_top #(
   parameter int REPEAT_LIMIT = 10,
   parameter int TICK_BITS    = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [krt_pkg::TICK_PORT_BITS-1:0]  req_tdata,   // now_tick[31:0]
   input  logic [krt_pkg::REQ_TYPE_BITS-1:0]   req_tuser,   // req_type[1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [krt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,   // repeat_count[3:0]
   input  logic                                csr_we,
   input  logic [krt_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [krt_pkg::HOLD_BITS-1:0]       csr_wdata
);
   import krt_pkg::*;

   localparam int DW = TICK_BITS - 1;
   localparam int EW = TICK_BITS + 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIFF = 2'd1;
   localparam logic [1:0] ST_ELAP = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [HOLD_BITS-1:0]     hold_ff, hold_in;
   logic [INTERVAL_BITS-1:0] interval_ff, interval_in;
   logic                     held_ff, held_in;
   logic [TICK_BITS-1:0]     press_ff, press_in;
   logic [DW-1:0]            rsf_ff, rsf_in;
   logic [TICK_BITS-1:0]     now_ff, now_in;
   logic [TICK_BITS-1:0]     diff_ff, diff_in;
   logic                     zero_ff, zero_in;
   logic                     wait_ff, wait_in;

   logic                     accept;
   logic                     disabled;
   logic [EW-1:0]            elapsed;
   logic                     div_start;
   logic [DW-1:0]            quotient;
   div_stat_type             div_stat;
   logic [DW:0]              ret;
   logic [DW:0]              capped;
   logic                     out_free;
   logic                     out_load;
   logic [COUNT_BITS-1:0]    out_count;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign disabled   = ~held_ff | hold_ff[HOLD_BITS-1] | (interval_ff == '0);
   assign elapsed    = {{2{diff_ff[TICK_BITS-1]}}, diff_ff}
                       - EW'(hold_ff[HOLD_BITS-2:0]);

   assign ret = {1'b0, quotient} - {1'b0, rsf_ff};

   always_comb begin
      if (ret[DW]) begin
         capped = '0;
      end else if (ret > (DW+1)'(REPEAT_LIMIT)) begin
         capped = (DW+1)'(REPEAT_LIMIT);
      end else begin
         capped = ret;
      end
   end

   always_comb begin
      state_in    = state_ff;
      hold_in     = hold_ff;
      interval_in = interval_ff;
      held_in     = held_ff;
      press_in    = press_ff;
      rsf_in      = rsf_ff;
      now_in      = now_ff;
      diff_in     = diff_ff;
      zero_in     = zero_ff;
      wait_in     = wait_ff;
      div_start   = 1'b0;
      out_load    = 1'b0;
      out_count   = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_HOLD_TIME:     hold_in     = csr_wdata;
            CSR_INTERVAL_TIME: interval_in = csr_wdata[INTERVAL_BITS-1:0];
            default:           ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  REQ_PRESS: begin
                     held_in  = 1'b1;
                     press_in = req_tdata[TICK_BITS-1:0];
                     rsf_in   = '0;
                  end
                  REQ_RELEASE: begin
                     held_in = 1'b0;
                  end
                  REQ_POLL: begin
                     now_in = req_tdata[TICK_BITS-1:0];
                     if (disabled) begin
                        zero_in  = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        zero_in  = 1'b0;
                        state_in = ST_DIFF;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIFF: begin
            diff_in  = now_ff - press_ff;
            state_in = ST_ELAP;
         end
         ST_ELAP: begin
            if (elapsed[EW-1]) begin
               zero_in = 1'b1;
               wait_in = 1'b0;
            end else begin
               div_start = 1'b1;
               wait_in   = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (wait_ff) begin
               if (div_stat.done) begin
                  wait_in = 1'b0;
               end
            end else if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               if (!zero_ff) begin
                  out_count = capped[COUNT_BITS-1:0];
                  rsf_in    = quotient;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         hold_ff     <= HOLD_RESET;
         interval_ff <= INTERVAL_RESET;
         held_ff     <= 1'b0;
         press_ff    <= '0;
         rsf_ff      <= '0;
         zero_ff     <= 1'b0;
         wait_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         hold_ff     <= hold_in;
         interval_ff <= interval_in;
         held_ff     <= held_in;
         press_ff    <= press_in;
         rsf_ff      <= rsf_in;
         zero_ff     <= zero_in;
         wait_ff     <= wait_in;
      end
      now_ff  <= now_in;
      diff_ff <= diff_in;
   end

   krt_div #(
      .DW (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (elapsed[DW-1:0]),
      .divisor  (interval_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   krt_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .count      (out_count),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
